FILE: rtl/core/ctpt_pkg.sv
package ctpt_pkg;

  typedef enum logic [2:0] {
    REG_A   = 3'd0,
    REG_B   = 3'd1,
    REG_AB  = 3'd2,
    REG_C   = 3'd3,
    REG_AC  = 3'd4,
    REG_BC  = 3'd5,
    REG_INT = 3'd6
  } region_t;

endpackage

FILE: rtl/core/ctpt_front.sv
module ctpt_front #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                           clk,
  input  logic [2:0]                                     en,
  input  logic signed [COORD_WIDTH-1:0]                  pnt [3],
  input  logic signed [COORD_WIDTH-1:0]                  vta [3],
  input  logic signed [COORD_WIDTH-1:0]                  vtb [3],
  input  logic signed [COORD_WIDTH-1:0]                  vtc [3],
  output logic signed [2*COORD_WIDTH+4-FRAC_BITS-1:0]    d   [6],
  output logic [18*COORD_WIDTH+9-1:0]                    geo
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int SUMW = PW + 2;
  localparam int GW   = 18 * CW + 9;

  logic signed [CW-1:0] s0_a [3];
  logic signed [CW-1:0] s0_b [3];
  logic signed [CW-1:0] s0_c [3];
  logic signed [EW-1:0] s0_ab [3];
  logic signed [EW-1:0] s0_ac [3];
  logic signed [EW-1:0] s0_bc [3];
  logic signed [EW-1:0] s0_ap [3];
  logic signed [EW-1:0] s0_bp [3];
  logic signed [EW-1:0] s0_cp [3];
  logic [GW-1:0] geo_s0;
  logic [GW-1:0] s1_geo;
  logic signed [PW-1:0] s1_pr [6][3];
  logic signed [SUMW-1:0] dsum [6];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s0_a[i]  <= vta[i];
        s0_b[i]  <= vtb[i];
        s0_c[i]  <= vtc[i];
        s0_ab[i] <= EW'(vtb[i]) - EW'(vta[i]);
        s0_ac[i] <= EW'(vtc[i]) - EW'(vta[i]);
        s0_bc[i] <= EW'(vtc[i]) - EW'(vtb[i]);
        s0_ap[i] <= EW'(pnt[i]) - EW'(vta[i]);
        s0_bp[i] <= EW'(pnt[i]) - EW'(vtb[i]);
        s0_cp[i] <= EW'(pnt[i]) - EW'(vtc[i]);
      end
    end
  end

  always_comb begin
    geo_s0 = '0;
    for (int i = 0; i < 3; i++) begin
      geo_s0[i*CW +: CW]                = s0_a[i];
      geo_s0[(3+i)*CW +: CW]            = s0_b[i];
      geo_s0[(6+i)*CW +: CW]            = s0_c[i];
      geo_s0[9*CW + i*EW +: EW]         = s0_ab[i];
      geo_s0[9*CW + (3+i)*EW +: EW]     = s0_ac[i];
      geo_s0[9*CW + (6+i)*EW +: EW]     = s0_bc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_geo <= geo_s0;
      for (int i = 0; i < 3; i++) begin
        s1_pr[0][i] <= PW'(s0_ab[i]) * PW'(s0_ap[i]);
        s1_pr[1][i] <= PW'(s0_ac[i]) * PW'(s0_ap[i]);
        s1_pr[2][i] <= PW'(s0_ab[i]) * PW'(s0_bp[i]);
        s1_pr[3][i] <= PW'(s0_ac[i]) * PW'(s0_bp[i]);
        s1_pr[4][i] <= PW'(s0_ab[i]) * PW'(s0_cp[i]);
        s1_pr[5][i] <= PW'(s0_ac[i]) * PW'(s0_cp[i]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dsum[k] = SUMW'(s1_pr[k][0]) + SUMW'(s1_pr[k][1]) + SUMW'(s1_pr[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      geo <= s1_geo;
      for (int k = 0; k < 6; k++) begin
        d[k] <= dsum[k][SUMW-1:FRAC_BITS];
      end
    end
  end

endmodule

FILE: rtl/core/ctpt_region.sv
module ctpt_region #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                              clk,
  input  logic [3:0]                                        en,
  input  logic signed [2*COORD_WIDTH+4-FRAC_BITS-1:0]       d    [6],
  input  logic [18*COORD_WIDTH+9-1:0]                       geo,
  output logic signed [2*(2*COORD_WIDTH+4-FRAC_BITS)+4-1:0] num0,
  output logic signed [2*(2*COORD_WIDTH+4-FRAC_BITS)+4-1:0] num1,
  output logic signed [2*(2*COORD_WIDTH+4-FRAC_BITS)+4-1:0] den,
  output logic [9*COORD_WIDTH+10-1:0]                       side
);

  localparam int CW  = COORD_WIDTH;
  localparam int EW  = CW + 1;
  localparam int GW  = 18 * CW + 9;
  localparam int DW  = 2 * CW + 4 - FRAC_BITS;
  localparam int L   = DW / 2;
  localparam int H   = DW - L;
  localparam int HHW = 2 * H;
  localparam int HLW = H + L + 1;
  localparam int LLW = 2 * L;
  localparam int PRW = 2 * DW;
  localparam int VW  = 2 * DW + 1;
  localparam int NW  = 2 * DW + 4;
  localparam int EDW = DW + 2;
  localparam int E1O = 3 * CW;
  localparam int E2O = 3 * CW + 3 * EW;
  localparam int DGO = 3 * CW + 6 * EW;
  localparam int RGO = DGO + 1;
  localparam int SW  = RGO + 3;

  logic signed [DW-1:0] ox [6];
  logic signed [DW-1:0] oy [6];
  logic signed [HHW-1:0] s3_hh [6];
  logic signed [HLW-1:0] s3_hl [6];
  logic signed [HLW-1:0] s3_lh [6];
  logic [LLW-1:0] s3_ll [6];
  logic [5:0] fl;
  logic [5:0] s3_fl;
  logic [5:0] s4_fl;
  logic signed [EDW-1:0] t43, t56;
  logic signed [EDW-1:0] s3_nab, s3_dab, s3_nac, s3_dac, s3_nbc, s3_dbc;
  logic signed [EDW-1:0] s4_nab, s4_dab, s4_nac, s4_dac, s4_nbc, s4_dbc;
  logic [GW-1:0] s3_geo;
  logic [GW-1:0] s4_geo;
  logic signed [PRW-1:0] pr [6];
  logic signed [VW-1:0] s4_vc, s4_vb, s4_va;

  logic signed [NW-1:0] den_sum;
  logic signed [CW-1:0] ga [3];
  logic signed [CW-1:0] gb [3];
  logic signed [CW-1:0] gc [3];
  logic signed [EW-1:0] gab [3];
  logic signed [EW-1:0] gac [3];
  logic signed [EW-1:0] gbc [3];
  logic signed [CW-1:0] base_n [3];
  logic signed [EW-1:0] e1_n [3];
  logic signed [EW-1:0] e2_n [3];
  ctpt_pkg::region_t rg_n;
  logic dg_n;
  logic neg_n;
  logic signed [NW-1:0] n0_n, n1_n, dn_n;
  logic [SW-1:0] side_n;

  logic [SW-1:0] s5_side;
  logic signed [NW-1:0] s5_num0, s5_num1, s5_den;
  logic s5_neg;

  always_comb begin
    ox[0] = d[0]; oy[0] = d[3];
    ox[1] = d[2]; oy[1] = d[1];
    ox[2] = d[4]; oy[2] = d[1];
    ox[3] = d[0]; oy[3] = d[5];
    ox[4] = d[2]; oy[4] = d[5];
    ox[5] = d[4]; oy[5] = d[3];
    t43 = EDW'(d[3]) - EDW'(d[2]);
    t56 = EDW'(d[4]) - EDW'(d[5]);
    fl[0] = (d[0] <= 0) && (d[1] <= 0);
    fl[1] = (d[2] >= 0) && (d[3] <= d[2]);
    fl[2] = (d[0] >= 0) && (d[2] <= 0);
    fl[3] = (d[5] >= 0) && (d[4] <= d[5]);
    fl[4] = (d[1] >= 0) && (d[5] <= 0);
    fl[5] = (t43 >= 0) && (t56 >= 0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 6; k++) begin
        s3_hh[k] <= HHW'($signed(ox[k][DW-1:L])) * HHW'($signed(oy[k][DW-1:L]));
        s3_hl[k] <= HLW'($signed(ox[k][DW-1:L])) * HLW'($signed({1'b0, oy[k][L-1:0]}));
        s3_lh[k] <= HLW'($signed({1'b0, ox[k][L-1:0]})) * HLW'($signed(oy[k][DW-1:L]));
        s3_ll[k] <= LLW'(ox[k][L-1:0]) * LLW'(oy[k][L-1:0]);
      end
      s3_fl  <= fl;
      s3_nab <= EDW'(d[0]);
      s3_dab <= EDW'(d[0]) - EDW'(d[2]);
      s3_nac <= EDW'(d[1]);
      s3_dac <= EDW'(d[1]) - EDW'(d[5]);
      s3_nbc <= t43;
      s3_dbc <= t43 + t56;
      s3_geo <= geo;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pr[k] = (PRW'(s3_hh[k]) <<< (2 * L))
            + ((PRW'(s3_hl[k]) + PRW'(s3_lh[k])) <<< L)
            + $signed(PRW'(s3_ll[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s4_vc  <= VW'(pr[0]) - VW'(pr[1]);
      s4_vb  <= VW'(pr[2]) - VW'(pr[3]);
      s4_va  <= VW'(pr[4]) - VW'(pr[5]);
      s4_fl  <= s3_fl;
      s4_nab <= s3_nab;
      s4_dab <= s3_dab;
      s4_nac <= s3_nac;
      s4_dac <= s3_dac;
      s4_nbc <= s3_nbc;
      s4_dbc <= s3_dbc;
      s4_geo <= s3_geo;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ga[i]  = s4_geo[i*CW +: CW];
      gb[i]  = s4_geo[(3+i)*CW +: CW];
      gc[i]  = s4_geo[(6+i)*CW +: CW];
      gab[i] = s4_geo[9*CW + i*EW +: EW];
      gac[i] = s4_geo[9*CW + (3+i)*EW +: EW];
      gbc[i] = s4_geo[9*CW + (6+i)*EW +: EW];
    end
    den_sum = NW'(s4_va) + NW'(s4_vb) + NW'(s4_vc);
    rg_n  = ctpt_pkg::REG_A;
    dg_n  = 1'b0;
    neg_n = 1'b0;
    n0_n  = '0;
    n1_n  = '0;
    dn_n  = NW'(1);
    for (int i = 0; i < 3; i++) begin
      base_n[i] = ga[i];
      e1_n[i]   = '0;
      e2_n[i]   = '0;
    end
    if (s4_fl[0]) begin
      rg_n = ctpt_pkg::REG_A;
    end else if (s4_fl[1]) begin
      rg_n = ctpt_pkg::REG_B;
      for (int i = 0; i < 3; i++) base_n[i] = gb[i];
    end else if ((s4_vc <= 0) && s4_fl[2]) begin
      rg_n = ctpt_pkg::REG_AB;
      for (int i = 0; i < 3; i++) e1_n[i] = gab[i];
      n0_n = NW'(s4_nab);
      dn_n = NW'(s4_dab);
    end else if (s4_fl[3]) begin
      rg_n = ctpt_pkg::REG_C;
      for (int i = 0; i < 3; i++) base_n[i] = gc[i];
    end else if ((s4_vb <= 0) && s4_fl[4]) begin
      rg_n = ctpt_pkg::REG_AC;
      for (int i = 0; i < 3; i++) e1_n[i] = gac[i];
      n0_n = NW'(s4_nac);
      dn_n = NW'(s4_dac);
    end else if ((s4_va <= 0) && s4_fl[5]) begin
      rg_n = ctpt_pkg::REG_BC;
      for (int i = 0; i < 3; i++) begin
        base_n[i] = gb[i];
        e1_n[i]   = gbc[i];
      end
      n0_n = NW'(s4_nbc);
      dn_n = NW'(s4_dbc);
    end else if (den_sum == 0) begin
      rg_n = ctpt_pkg::REG_A;
      dg_n = 1'b1;
    end else begin
      rg_n = ctpt_pkg::REG_INT;
      for (int i = 0; i < 3; i++) begin
        e1_n[i] = gab[i];
        e2_n[i] = gac[i];
      end
      n0_n  = NW'(s4_vb);
      n1_n  = NW'(s4_vc);
      dn_n  = den_sum;
      neg_n = den_sum < 0;
    end
    side_n = '0;
    for (int i = 0; i < 3; i++) begin
      side_n[i*CW +: CW]      = base_n[i];
      side_n[E1O + i*EW +: EW] = e1_n[i];
      side_n[E2O + i*EW +: EW] = e2_n[i];
    end
    side_n[DGO]       = dg_n;
    side_n[RGO +: 3]  = rg_n;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s5_side <= side_n;
      s5_num0 <= n0_n;
      s5_num1 <= n1_n;
      s5_den  <= dn_n;
      s5_neg  <= neg_n;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      side <= s5_side;
      num0 <= s5_neg ? -s5_num0 : s5_num0;
      num1 <= s5_neg ? -s5_num1 : s5_num1;
      den  <= s5_neg ? -s5_den : s5_den;
    end
  end

endmodule

FILE: rtl/core/ctpt_div.sv
module ctpt_div #(
  parameter int NW        = 68,
  parameter int FRAC_BITS = 16,
  parameter int SW        = 232
) (
  input  logic                  clk,
  input  logic [FRAC_BITS:0]    en,
  input  logic signed [NW-1:0]  num0,
  input  logic signed [NW-1:0]  num1,
  input  logic signed [NW-1:0]  den,
  input  logic [SW-1:0]         side_in,
  output logic [FRAC_BITS:0]    w0,
  output logic [FRAC_BITS:0]    w1,
  output logic [SW-1:0]         side_out
);

  localparam int F = FRAC_BITS;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [NW-1:0] r0 [F+1];
  logic [NW-1:0] r1 [F+1];
  logic [NW-1:0] dd [F+1];
  logic [F-1:0] q0 [F+1];
  logic [F-1:0] q1 [F+1];
  logic [F:0] z0, f0, z1, f1;
  logic [SW-1:0] sd [F+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0[0] <= num0;
      r1[0] <= num1;
      dd[0] <= den;
      q0[0] <= '0;
      q1[0] <= '0;
      z0[0] <= (num0 <= 0) || (den <= 0);
      z1[0] <= (num1 <= 0) || (den <= 0);
      f0[0] <= num0 >= den;
      f1[0] <= num1 >= den;
      sd[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_bit
    logic [NW:0] t0, t1, n0, n1;
    logic ge0, ge1;

    always_comb begin
      t0  = {r0[k-1], 1'b0};
      t1  = {r1[k-1], 1'b0};
      ge0 = t0 >= {1'b0, dd[k-1]};
      ge1 = t1 >= {1'b0, dd[k-1]};
      n0  = ge0 ? t0 - {1'b0, dd[k-1]} : t0;
      n1  = ge1 ? t1 - {1'b0, dd[k-1]} : t1;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        r0[k] <= n0[NW-1:0];
        r1[k] <= n1[NW-1:0];
        dd[k] <= dd[k-1];
        q0[k] <= {q0[k-1][F-2:0], ge0};
        q1[k] <= {q1[k-1][F-2:0], ge1};
        z0[k] <= z0[k-1];
        z1[k] <= z1[k-1];
        f0[k] <= f0[k-1];
        f1[k] <= f1[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign w0 = z0[F] ? '0 : (f0[F] ? ONE : {1'b0, q0[F]});
  assign w1 = z1[F] ? '0 : (f1[F] ? ONE : {1'b0, q1[F]});
  assign side_out = sd[F];

endmodule

FILE: rtl/core/ctpt_place.sv
module ctpt_place #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic [1:0]                     en,
  input  logic [FRAC_BITS:0]             w0,
  input  logic [FRAC_BITS:0]             w1,
  input  logic [9*COORD_WIDTH+10-1:0]    side,
  output logic signed [COORD_WIDTH-1:0]  near_x,
  output logic signed [COORD_WIDTH-1:0]  near_y,
  output logic signed [COORD_WIDTH-1:0]  near_z,
  output logic [FRAC_BITS:0]             weight_a,
  output logic [FRAC_BITS:0]             weight_b,
  output logic [FRAC_BITS:0]             weight_c,
  output logic [2:0]                     region,
  output logic                           degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int EW  = CW + 1;
  localparam int E1O = 3 * CW;
  localparam int E2O = 3 * CW + 3 * EW;
  localparam int DGO = 3 * CW + 6 * EW;
  localparam int RGO = DGO + 1;
  localparam int MW  = CW + F + 3;
  localparam int SMW = MW + 1;
  localparam int NSW = CW + 5;
  localparam int WSW = F + 3;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [SMW-1:0] HALF = {{(SMW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [NSW-1:0] NMAX = {{6{1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [NSW-1:0] NMIN = {{6{1'b1}}, {(CW-1){1'b0}}};

  ctpt_pkg::region_t rg;
  logic signed [WSW-1:0] wint;
  logic [F:0] wa_n, wb_n, wc_n;

  logic signed [CW-1:0] s_base [3];
  logic signed [MW-1:0] s_p1 [3];
  logic signed [MW-1:0] s_p2 [3];
  logic [F:0] s_wa, s_wb, s_wc;
  logic [2:0] s_rg;
  logic s_dg;

  logic signed [SMW-1:0] sum [3];
  logic signed [NSW-1:0] nv [3];
  logic signed [CW-1:0] sat [3];

  always_comb begin
    rg   = ctpt_pkg::region_t'(side[RGO +: 3]);
    wint = WSW'({1'b0, ONE}) - WSW'({1'b0, w0}) - WSW'({1'b0, w1});
    wa_n = '0;
    wb_n = '0;
    wc_n = '0;
    unique case (rg)
      ctpt_pkg::REG_A:  wa_n = ONE;
      ctpt_pkg::REG_B:  wb_n = ONE;
      ctpt_pkg::REG_C:  wc_n = ONE;
      ctpt_pkg::REG_AB: begin
        wb_n = w0;
        wa_n = ONE - w0;
      end
      ctpt_pkg::REG_AC: begin
        wc_n = w0;
        wa_n = ONE - w0;
      end
      ctpt_pkg::REG_BC: begin
        wc_n = w0;
        wb_n = ONE - w0;
      end
      ctpt_pkg::REG_INT: begin
        wb_n = w0;
        wc_n = w1;
        wa_n = (wint < 0) ? '0 : wint[F:0];
      end
      default: wa_n = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s_base[i] <= side[i*CW +: CW];
        s_p1[i]   <= MW'($signed(side[E1O + i*EW +: EW])) * MW'($signed({1'b0, w0}));
        s_p2[i]   <= MW'($signed(side[E2O + i*EW +: EW])) * MW'($signed({1'b0, w1}));
      end
      s_wa <= wa_n;
      s_wb <= wb_n;
      s_wc <= wc_n;
      s_rg <= side[RGO +: 3];
      s_dg <= side[DGO];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SMW'(s_p1[i]) + SMW'(s_p2[i]) + $signed(HALF);
      nv[i]  = NSW'(s_base[i]) + NSW'($signed(sum[i][SMW-1:F]));
      if (nv[i] > NMAX) begin
        sat[i] = NMAX[CW-1:0];
      end else if (nv[i] < NMIN) begin
        sat[i] = NMIN[CW-1:0];
      end else begin
        sat[i] = nv[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      near_x     <= sat[0];
      near_y     <= sat[1];
      near_z     <= sat[2];
      weight_a   <= s_wa;
      weight_b   <= s_wb;
      weight_c   <= s_wc;
      region     <= s_rg;
      degenerate <= s_dg;
    end
  end

endmodule

FILE: rtl/core/closest_point_on_triangle_unit.sv
// Closest point on a triangle to a query point, by Voronoi region tests (vertex A, vertex B,
// edge AB, vertex C, edge AC, edge BC, interior). Coordinates are signed fixed point with
// FRAC_BITS fraction bits; weights are unsigned with FRAC_BITS fraction bits. The block takes
// one word per cycle while in_ready is high and holds up to FRAC_BITS+10 words in flight;
// the weight divider resolves one quotient bit per pipeline stage. Stalls on the output
// squeeze out bubbles first, so the input keeps taking words while any stage is empty. A
// triangle whose interior denominator is zero and whose query falls in no vertex or edge
// region reports vertex A, weights (1,0,0), region A and the degenerate flag.
module closest_point_on_triangle_unit #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] query_x,
  input  logic signed [COORD_WIDTH-1:0] query_y,
  input  logic signed [COORD_WIDTH-1:0] query_z,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] near_x,
  output logic signed [COORD_WIDTH-1:0] near_y,
  output logic signed [COORD_WIDTH-1:0] near_z,
  output logic [FRAC_BITS:0]            weight_a,
  output logic [FRAC_BITS:0]            weight_b,
  output logic [FRAC_BITS:0]            weight_c,
  output logic [2:0]                    region,
  output logic                          degenerate
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * CW + 4 - F;
  localparam int NW = 2 * DW + 4;
  localparam int GW = 18 * CW + 9;
  localparam int SW = 9 * CW + 10;
  localparam int NS = F + 10;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic signed [CW-1:0] pnt [3];
  logic signed [CW-1:0] vta [3];
  logic signed [CW-1:0] vtb [3];
  logic signed [CW-1:0] vtc [3];
  logic signed [DW-1:0] d [6];
  logic [GW-1:0] geo;
  logic signed [NW-1:0] num0, num1, den;
  logic [SW-1:0] side_r;
  logic [SW-1:0] side_d;
  logic [F:0] w0, w1;

  assign pnt[0] = query_x;
  assign pnt[1] = query_y;
  assign pnt[2] = query_z;
  assign vta[0] = vert_a_x;
  assign vta[1] = vert_a_y;
  assign vta[2] = vert_a_z;
  assign vtb[0] = vert_b_x;
  assign vtb[1] = vert_b_y;
  assign vtb[2] = vert_b_z;
  assign vtc[0] = vert_c_x;
  assign vtc[1] = vert_c_y;
  assign vtc[2] = vert_c_z;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  ctpt_front #(
    .COORD_WIDTH(CW),
    .FRAC_BITS(F)
  ) u_front (
    .clk (clk),
    .en  (en[2:0]),
    .pnt (pnt),
    .vta (vta),
    .vtb (vtb),
    .vtc (vtc),
    .d   (d),
    .geo (geo)
  );

  ctpt_region #(
    .COORD_WIDTH(CW),
    .FRAC_BITS(F)
  ) u_region (
    .clk  (clk),
    .en   (en[6:3]),
    .d    (d),
    .geo  (geo),
    .num0 (num0),
    .num1 (num1),
    .den  (den),
    .side (side_r)
  );

  ctpt_div #(
    .NW(NW),
    .FRAC_BITS(F),
    .SW(SW)
  ) u_div (
    .clk      (clk),
    .en       (en[7+F:7]),
    .num0     (num0),
    .num1     (num1),
    .den      (den),
    .side_in  (side_r),
    .w0       (w0),
    .w1       (w1),
    .side_out (side_d)
  );

  ctpt_place #(
    .COORD_WIDTH(CW),
    .FRAC_BITS(F)
  ) u_place (
    .clk        (clk),
    .en         (en[9+F:8+F]),
    .w0         (w0),
    .w1         (w1),
    .side       (side_d),
    .near_x     (near_x),
    .near_y     (near_y),
    .near_z     (near_z),
    .weight_a   (weight_a),
    .weight_b   (weight_b),
    .weight_c   (weight_c),
    .region     (region),
    .degenerate (degenerate)
  );

endmodule

FILE: rtl/core/ctpt_chk.sv
module ctpt_chk #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [COORD_WIDTH-1:0] query_x,
  input logic signed [COORD_WIDTH-1:0] query_y,
  input logic signed [COORD_WIDTH-1:0] query_z,
  input logic signed [COORD_WIDTH-1:0] vert_a_x,
  input logic signed [COORD_WIDTH-1:0] vert_a_y,
  input logic signed [COORD_WIDTH-1:0] vert_a_z,
  input logic signed [COORD_WIDTH-1:0] vert_b_x,
  input logic signed [COORD_WIDTH-1:0] vert_b_y,
  input logic signed [COORD_WIDTH-1:0] vert_b_z,
  input logic signed [COORD_WIDTH-1:0] vert_c_x,
  input logic signed [COORD_WIDTH-1:0] vert_c_y,
  input logic signed [COORD_WIDTH-1:0] vert_c_z,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] near_x,
  input logic signed [COORD_WIDTH-1:0] near_y,
  input logic signed [COORD_WIDTH-1:0] near_z,
  input logic [FRAC_BITS:0]            weight_a,
  input logic [FRAC_BITS:0]            weight_b,
  input logic [FRAC_BITS:0]            weight_c,
  input logic [2:0]                    region,
  input logic                          degenerate
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+2:0] ONE_W = {2'b00, ONE};

  logic [FRAC_BITS+2:0] wsum;

  assign wsum = {2'b00, weight_a} + {2'b00, weight_b} + {2'b00, weight_c};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_degen_vertex: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> region == ctpt_pkg::REG_A && weight_a == ONE
      && weight_b == '0 && weight_c == '0)
    else $error("degenerate result is not vertex A");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && region != ctpt_pkg::REG_INT |-> wsum == ONE_W)
    else $error("vertex or edge weights do not sum to one");

endmodule

bind closest_point_on_triangle_unit ctpt_chk #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS(FRAC_BITS)
) u_chk (.*);
